// ===== rtl/core/piecewise_db_volume_gain_assert.svh =====
// assertion macros for the piecewise dB volume stage
// the macros assume a clock clk_i and an active low reset rst_ni in scope
`ifndef PIECEWISE_DB_VOLUME_GAIN_ASSERT_SVH
`define PIECEWISE_DB_VOLUME_GAIN_ASSERT_SVH
`ifndef SYNTHESIS
`define PWDB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PWDB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PWDB_ASSERT_IMP(lbl, ante, cons)
`define PWDB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/pwdb_pkg.sv =====
// types and constants of the piecewise dB volume stage
// no dependencies
`timescale 1ns / 1ps
package pwdb_pkg;
  localparam int NUM_SEGMENTS = 8;
  localparam int SEG_IDX_W    = 3;
  localparam int SEG_CNT_W    = 4;

  localparam logic [1:0] FN_SAMPLE = 2'd0;
  localparam logic [1:0] FN_VOLUME = 2'd1;
  localparam logic [1:0] FN_MUTE   = 2'd2;
  localparam logic [1:0] FN_SEG    = 2'd3;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_REJECT = 2'd1;
  localparam logic [1:0] STS_MISS   = 2'd2;
  localparam logic [1:0] STS_SAT    = 2'd3;

  localparam logic [23:0] GAIN_MAX   = 24'hFF_FFFF;
  localparam logic [23:0] UNITY_GAIN = 24'h01_0000;
  localparam logic [22:0] LOG2_10_OVER_20_Q24 = 23'd2786635;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [31:0] FLAT_SLOPE = 32'h0100_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] sample_in;
    logic               block_end;
    logic [9:0]         volume;
    logic               mute;
    logic [2:0]         segment_index;
    logic [9:0]         seg_min_volume;
    logic [9:0]         seg_max_volume;
    logic signed [15:0] seg_min_db;
    logic signed [15:0] seg_max_db;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_out;
    logic               last_of_block;
    logic [23:0]        gain;
    logic               muted;
    logic [1:0]         status;
    logic [2:0]         matched_segment;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic smp;
    logic set_mute;
    logic set_reject;
    logic set_miss;
    logic wr_flat;
    logic div_slope;
    logic wr_div;
    logic seg_next;
    logic step_mul;
    logic db_calc;
    logic exp_mul;
    logic y_init;
    logic term_mul;
    logic term_acc;
    logic gain_sat;
    logic gain_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       reject;
    logic       flat;
    logic       seg_valid;
    logic       seg_hit;
    logic       ip_sat;
    logic       div_done;
    logic       n_last;
    logic       out_free;
  } sts_t;
endpackage

// ===== rtl/core/pwdb_div.sv =====
// restoring divider, one quotient bit per cycle, 32 by 10 bits
// depends on nothing
`timescale 1ns / 1ps
module pwdb_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [9:0]  divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [31:0] quo_q, quo_d;
  logic [9:0]  rem_q, rem_d, dvs_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [10:0] trial;
  logic        ge;

  always_comb begin
    trial = {rem_q, quo_q[31]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? 10'(trial - {1'b0, dvs_q}) : trial[9:0];
    quo_d = {quo_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/pwdb_dp.sv =====
// datapath: segment table, gain evaluation, sample scaling, output register
// depends on pwdb_pkg and pwdb_div
`timescale 1ns / 1ps
module pwdb_dp import pwdb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  in_item_t             in_item_i,
  input  logic                 cfg_valid_i,
  input  logic [SEG_CNT_W-1:0] cfg_data_i,
  input  logic                 out_stall_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  output out_item_t            out_item_o
);
  in_item_t             item_q;
  logic [SEG_CNT_W-1:0] cnt_q, act;
  logic [9:0]           lo_q   [NUM_SEGMENTS];
  logic [9:0]           hi_q   [NUM_SEGMENTS];
  logic signed [15:0]   base_q [NUM_SEGMENTS];
  logic [31:0]          slope_q[NUM_SEGMENTS];
  logic [23:0]          gain_q, gain_d;
  logic                 mute_q;
  logic [SEG_IDX_W-1:0] last_seg_q;
  logic [SEG_CNT_W-1:0] seg_i_q;
  logic [SEG_IDX_W-1:0] si;
  logic [25:0]          step_q;
  logic signed [27:0]   db_q;
  logic signed [50:0]   p_q;
  logic signed [18:0]   ip_q;
  logic [29:0]          y_q;
  logic [30:0]          term_q, tp_q;
  logic [31:0]          sum_q;
  logic [3:0]           n_q;
  logic [15:0]          smp_q, smp_d;
  logic [1:0]           sts_q;
  logic                 sat;
  logic                 out_valid_q;
  out_item_t            out_q;
  logic [41:0]          step_prod;
  logic [45:0]          y_prod;
  logic [60:0]          t_prod;
  logic [16:0]          mag;
  logic [40:0]          s_prod;
  logic [24:0]          pr;
  logic [5:0]           sh_amt;
  logic [40:0]          rnd, shv;
  logic [15:0]          ddiff;
  logic [31:0]          rcp_m;
  logic [5:0]           rcp_k;
  logic [62:0]          rcp_prod;
  logic [30:0]          term_div;
  logic                 div_start, div_done;
  logic [31:0]          div_dividend, div_quo;
  logic [9:0]           div_divisor;

  assign act = (cnt_q > SEG_CNT_W'(NUM_SEGMENTS)) ? SEG_CNT_W'(NUM_SEGMENTS) : cnt_q;
  assign si  = seg_i_q[SEG_IDX_W-1:0];
  assign ddiff = item_q.seg_max_db - item_q.seg_min_db;

  always_comb begin
    step_prod = slope_q[si] * 42'(item_q.volume - lo_q[si]);
    y_prod    = p_q[31:16] * LN2_Q30;
    t_prod    = term_q * y_q;
    mag = item_q.sample_in[15] ? 17'(-{item_q.sample_in[15], item_q.sample_in})
                               : {1'b0, item_q.sample_in};
    s_prod = mag * gain_q;
    pr     = s_prod[40:16];
    sat    = 1'b0;
    if (mute_q) begin
      smp_d = '0;
    end else if (!item_q.sample_in[15]) begin
      if (pr > 25'd32767) begin
        smp_d = 16'h7FFF;
        sat   = 1'b1;
      end else begin
        smp_d = pr[15:0];
      end
    end else begin
      if (pr > 25'd32768) begin
        smp_d = 16'h8000;
        sat   = 1'b1;
      end else begin
        smp_d = 16'(~pr[15:0] + 16'd1);
      end
    end
    sh_amt = 6'(19'sd14 - ip_q);
    rnd    = {9'd0, sum_q} + (41'd1 << (sh_amt - 6'd1));
    shv    = rnd >> sh_amt;
    if (ip_q < -19'sd26) begin
      gain_d = '0;
    end else if (shv > {17'd0, GAIN_MAX}) begin
      gain_d = GAIN_MAX;
    end else begin
      gain_d = shv[23:0];
    end
  end

  // series term divided by n through a reciprocal multiply, exact for 31-bit terms
  always_comb begin
    unique case (n_q)
      4'd2: begin
        rcp_m = 32'h8000_0000;
        rcp_k = 6'd32;
      end
      4'd3: begin
        rcp_m = 32'd2863311531;
        rcp_k = 6'd33;
      end
      4'd4: begin
        rcp_m = 32'h8000_0000;
        rcp_k = 6'd33;
      end
      4'd5: begin
        rcp_m = 32'd3435973837;
        rcp_k = 6'd34;
      end
      4'd6: begin
        rcp_m = 32'd2863311531;
        rcp_k = 6'd34;
      end
      4'd7: begin
        rcp_m = 32'd2454267027;
        rcp_k = 6'd34;
      end
      4'd8: begin
        rcp_m = 32'h8000_0000;
        rcp_k = 6'd34;
      end
      default: begin
        rcp_m = 32'h8000_0000;
        rcp_k = 6'd31;
      end
    endcase
    rcp_prod = tp_q * rcp_m;
    term_div = 31'(rcp_prod >> rcp_k);
  end

  assign div_start    = cmd_i.div_slope;
  assign div_dividend = {ddiff, 16'd0};
  assign div_divisor  = 10'(item_q.seg_max_volume - item_q.seg_min_volume);

  pwdb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      gain_q      <= UNITY_GAIN;
      mute_q      <= 1'b0;
      last_seg_q  <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_SEGMENTS; k++) begin
        lo_q[k]    <= '0;
        hi_q[k]    <= '0;
        base_q[k]  <= '0;
        slope_q[k] <= '0;
      end
    end else begin
      if (cfg_valid_i) cnt_q <= cfg_data_i;
      if (cmd_i.set_mute) mute_q <= item_q.mute;
      if (cmd_i.step_mul) last_seg_q <= si;
      if (cmd_i.gain_sat) gain_q <= GAIN_MAX;
      if (cmd_i.gain_fin) gain_q <= gain_d;
      if (cmd_i.wr_flat || cmd_i.wr_div) begin
        lo_q[item_q.segment_index]    <= item_q.seg_min_volume;
        hi_q[item_q.segment_index]    <= item_q.seg_max_volume;
        base_q[item_q.segment_index]  <= item_q.seg_min_db;
        slope_q[item_q.segment_index] <= cmd_i.wr_flat ? FLAT_SLOPE : div_quo;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= in_item_i;
      seg_i_q <= '0;
      smp_q   <= '0;
      sts_q   <= STS_OK;
    end
    if (cmd_i.set_reject) sts_q <= STS_REJECT;
    if (cmd_i.set_miss)   sts_q <= STS_MISS;
    if (cmd_i.smp) begin
      smp_q <= smp_d;
      if (sat) sts_q <= STS_SAT;
    end
    if (cmd_i.seg_next) seg_i_q <= seg_i_q + SEG_CNT_W'(1);
    if (cmd_i.step_mul) step_q <= step_prod[41:16];
    if (cmd_i.db_calc)  db_q <= 28'(base_q[si]) + $signed({2'b00, step_q});
    if (cmd_i.exp_mul)  p_q <= db_q * $signed(LOG2_10_OVER_20_Q24);
    if (cmd_i.y_init) begin
      ip_q   <= p_q[50:32];
      y_q    <= y_prod[45:16];
      term_q <= 31'h4000_0000;
      sum_q  <= 32'h4000_0000;
      n_q    <= 4'd1;
    end
    if (cmd_i.term_mul) tp_q <= t_prod[60:30];
    if (cmd_i.term_acc) begin
      term_q <= term_div;
      sum_q  <= sum_q + {1'b0, term_div};
      n_q    <= n_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      out_q.kind            <= item_q.func;
      out_q.sample_out      <= (item_q.func == FN_SAMPLE) ? smp_q : '0;
      out_q.last_of_block   <= (item_q.func == FN_SAMPLE) & item_q.block_end;
      out_q.gain            <= gain_q;
      out_q.muted           <= mute_q;
      out_q.status          <= sts_q;
      out_q.matched_segment <= last_seg_q;
    end
  end

  always_comb begin
    sts_o.func      = item_q.func;
    sts_o.reject    = ({1'b0, item_q.segment_index} >= act)
                    || (item_q.seg_max_volume < item_q.seg_min_volume)
                    || (item_q.seg_max_db < item_q.seg_min_db);
    sts_o.flat      = item_q.seg_max_volume == item_q.seg_min_volume;
    sts_o.seg_valid = seg_i_q < act;
    sts_o.seg_hit   = (item_q.volume >= lo_q[si]) && (item_q.volume <= hi_q[si]);
    sts_o.ip_sat    = ip_q >= 19'sd8;
    sts_o.div_done  = div_done;
    sts_o.n_last    = n_q == 4'd8;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

// ===== rtl/core/pwdb_ctrl.sv =====
// controller state machine sequencing the datapath
// depends on pwdb_pkg
`timescale 1ns / 1ps
module pwdb_ctrl import pwdb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SMP, S_WWAIT, S_SRCH, S_DB, S_EXP, S_Y,
    S_CHK, S_TMUL, S_TDIV, S_FIN, S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.func)
          FN_SAMPLE: state_d = S_SMP;
          FN_VOLUME: state_d = S_SRCH;
          FN_MUTE: begin
            cmd_o.set_mute = 1'b1;
            state_d = S_OUT;
          end
          default: begin
            priority if (sts_i.reject) begin
              cmd_o.set_reject = 1'b1;
              state_d = S_OUT;
            end else if (sts_i.flat) begin
              cmd_o.wr_flat = 1'b1;
              state_d = S_OUT;
            end else begin
              cmd_o.div_slope = 1'b1;
              state_d = S_WWAIT;
            end
          end
        endcase
      end
      S_SMP: begin
        cmd_o.smp = 1'b1;
        state_d = S_OUT;
      end
      S_WWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.wr_div = 1'b1;
          state_d = S_OUT;
        end
      end
      S_SRCH: begin
        priority if (!sts_i.seg_valid) begin
          cmd_o.set_miss = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.seg_hit) begin
          cmd_o.step_mul = 1'b1;
          state_d = S_DB;
        end else begin
          cmd_o.seg_next = 1'b1;
        end
      end
      S_DB: begin
        cmd_o.db_calc = 1'b1;
        state_d = S_EXP;
      end
      S_EXP: begin
        cmd_o.exp_mul = 1'b1;
        state_d = S_Y;
      end
      S_Y: begin
        cmd_o.y_init = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.ip_sat) begin
          cmd_o.gain_sat = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd_o.term_mul = 1'b1;
        state_d = S_TDIV;
      end
      S_TDIV: begin
        cmd_o.term_acc = 1'b1;
        state_d = sts_i.n_last ? S_FIN : S_TMUL;
      end
      S_FIN: begin
        cmd_o.gain_fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = state_q != S_IDLE;
endmodule

// ===== rtl/core/piecewise_db_volume_gain.sv =====
// sample: decode, scale, output; mute: decode, output; sequenced by the controller
// segment write: decode, bit-serial divide, output; rejected or flat: decode, output
// volume: search of up to 8 segments, dB, exponent and series setup, then eight series
// terms, each a multiply then a divide; unmatched and saturated gain skip the series
// the output register lets the controller go idle while a result waits
// asynchronous active-low reset: unity gain, unmuted, empty segment table
`timescale 1ns / 1ps
`include "piecewise_db_volume_gain_assert.svh"
module piecewise_db_volume_gain import pwdb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SEG_CNT_W-1:0] cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pwdb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pwdb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  `PWDB_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `PWDB_ASSERT_IMP(a_nonsample_zero, out_valid_o && out_item_o.kind != FN_SAMPLE, out_item_o.sample_out == 16'd0)
  `PWDB_ASSERT_IMP(a_sat_only_sample, out_valid_o && out_item_o.status == STS_SAT, out_item_o.kind == FN_SAMPLE)
endmodule

// ===== sim/tb.sv =====
// testbench for piecewise_db_volume_gain: directed and random items checked against
// an in-bench predictor of the segment table, dB-to-gain conversion and sample gain
// depends on pwdb_pkg and the piecewise_db_volume_gain rtl
`timescale 1ns / 1ps
module tb;
  import pwdb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [SEG_CNT_W-1:0] cfg_data = '0;

  piecewise_db_volume_gain DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [3:0] seg_cnt;
  logic [9:0] tbl_lo [NUM_SEGMENTS];
  logic [9:0] tbl_hi [NUM_SEGMENTS];
  int tbl_db [NUM_SEGMENTS];
  logic [31:0] tbl_slope [NUM_SEGMENTS];
  logic [23:0] cur_gain;
  logic cur_mute;
  logic [2:0] cur_seg;

  out_item_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_sat = 0, n_miss = 0, n_rej = 0;
  int hold_off = 0;
  bit burst_mode = 1;

  function automatic logic [23:0] db_gain(input int db);
    longint p, e, ip;
    longint unsigned f, y, term, total;
    int s;
    p = longint'(db) * 2786635;
    if (p >= 0) e = p >>> 16;
    else e = -((-p + 65535) >>> 16);
    if (e >= 0) ip = e >>> 16;
    else ip = -((-e + 65535) >>> 16);
    f = e - ip * 65536;
    if (ip >= 8) return GAIN_MAX;
    y = (f * 64'd744261118) >> 16;
    term = 64'd1 << 30;
    total = term;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * y) >> 30) / n;
      total += term;
    end
    if (14 - ip > 40) return '0;
    s = int'(14 - ip);
    total = (total + (64'd1 << (s - 1))) >> s;
    return total > GAIN_MAX ? GAIN_MAX : total[23:0];
  endfunction

  function automatic out_item_t predict_volume_stage(input in_item_t it);
    out_item_t r;
    int active, x, db;
    longint unsigned mag, prod, stp;
    bit hit;
    r = '0;
    r.kind = it.func;
    active = seg_cnt > NUM_SEGMENTS ? NUM_SEGMENTS : seg_cnt;
    case (it.func)
      FN_SAMPLE: begin
        r.last_of_block = it.block_end;
        if (!cur_mute) begin
          x = it.sample_in;
          mag = x < 0 ? -x : x;
          prod = (mag * cur_gain) >> 16;
          if (x >= 0) begin
            if (prod > 32767) begin r.sample_out = 16'sh7fff; r.status = STS_SAT; end
            else r.sample_out = prod[15:0];
          end else begin
            if (prod > 32768) begin r.sample_out = 16'sh8000; r.status = STS_SAT; end
            else r.sample_out = -prod[15:0];
          end
        end
      end
      FN_VOLUME: begin
        hit = 0;
        for (int i = 0; i < active && !hit; i++) begin
          if (it.volume >= tbl_lo[i] && it.volume <= tbl_hi[i]) begin
            stp = (longint'(tbl_slope[i]) * (it.volume - tbl_lo[i])) >> 16;
            db = tbl_db[i] + int'(stp[31:0]);
            cur_gain = db_gain(db);
            cur_seg = 3'(i);
            hit = 1;
          end
        end
        if (!hit) r.status = STS_MISS;
      end
      FN_MUTE: cur_mute = it.mute;
      default: begin
        if (it.segment_index >= active || it.seg_max_volume < it.seg_min_volume ||
            it.seg_max_db < it.seg_min_db) begin
          r.status = STS_REJECT;
        end else begin
          tbl_lo[it.segment_index] = it.seg_min_volume;
          tbl_hi[it.segment_index] = it.seg_max_volume;
          tbl_db[it.segment_index] = it.seg_min_db;
          if (it.seg_max_volume == it.seg_min_volume)
            tbl_slope[it.segment_index] = FLAT_SLOPE;
          else
            tbl_slope[it.segment_index] = 32'(((longint'(int'(it.seg_max_db) -
              int'(it.seg_min_db)) & 64'hffff_ffff) << 16) /
              (it.seg_max_volume - it.seg_min_volume));
        end
      end
    endcase
    r.gain = cur_gain;
    r.muted = cur_mute;
    r.matched_segment = cur_seg;
    return r;
  endfunction

  // the item stays offered after acceptance until the next send or a drain replaces it
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_mode && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 0;
      in_item <= '0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_volume_stage(it));
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    in_item <= '0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_count(input logic [3:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    seg_cnt = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic in_item_t rand_item(input logic [1:0] fn);
    in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.func = fn;
    return it;
  endfunction

  function automatic in_item_t seg_item(input int idx, input int lo, input int hi,
                                        input int dlo, input int dhi);
    in_item_t it;
    it = rand_item(FN_SEG);
    it.segment_index = 3'(idx);
    it.seg_min_volume = 10'(lo);
    it.seg_max_volume = 10'(hi);
    it.seg_min_db = 16'(dlo);
    it.seg_max_db = 16'(dhi);
    return it;
  endfunction

  function automatic in_item_t vol_item(input int v);
    in_item_t it;
    it = rand_item(FN_VOLUME);
    it.volume = 10'(v);
    return it;
  endfunction

  function automatic in_item_t smp_item(input int s);
    in_item_t it;
    it = rand_item(FN_SAMPLE);
    it.sample_in = 16'(s);
    return it;
  endfunction

  function automatic in_item_t mute_item(input bit m);
    in_item_t it;
    it = rand_item(FN_MUTE);
    it.mute = m;
    return it;
  endfunction

  task automatic test_directed;
    in_item_t it;
    send_item(smp_item(32767));
    send_item(smp_item(-32768));
    send_item(vol_item(5));
    send_item(seg_item(0, 0, 10, 0, 256));
    write_count(4'd15);
    send_item(seg_item(0, 0, 100, -32768, 32767));
    send_item(seg_item(1, 200, 200, 0, 0));
    send_item(seg_item(2, 300, 200, 0, 10));
    send_item(seg_item(2, 300, 400, 10, 0));
    send_item(seg_item(3, 500, 1023, 0, 32767));
    send_item(seg_item(7, 0, 1023, 0, 0));
    send_item(vol_item(0));
    send_item(vol_item(100));
    send_item(vol_item(200));
    send_item(vol_item(1023));
    send_item(vol_item(450));
    send_item(smp_item(32767));
    send_item(smp_item(-32768));
    send_item(smp_item(-1));
    send_item(mute_item(1));
    send_item(smp_item(12345));
    send_item(mute_item(0));
    it = smp_item(1);
    it.block_end = 1;
    send_item(it);
  endtask

  task automatic test_random(input int count, input logic [3:0] cnt);
    in_item_t it;
    int k;
    write_count(cnt);
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        it = rand_item(FN_SAMPLE);
        if ($urandom_range(0, 3) == 0)
          it.sample_in = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end else if (k < 72) begin
        it = rand_item(FN_VOLUME);
      end else if (k < 80) begin
        it = rand_item(FN_MUTE);
      end else begin
        it = rand_item(FN_SEG);
        if ($urandom_range(0, 4) != 0) begin
          it.segment_index = 3'($urandom_range(0, 7));
          it.seg_min_volume = 10'($urandom_range(0, 1023));
          it.seg_max_volume = 10'($urandom_range(it.seg_min_volume, 1023));
          it.seg_min_db = 16'($urandom_range(0, 65535) - 32768);
          it.seg_max_db = 16'($urandom_range(int'(it.seg_min_db) + 32768, 65535) - 32768);
          if ($urandom_range(0, 1)) begin
            it.seg_min_db = 16'(int'($urandom_range(0, 12000)) - 9000);
            it.seg_max_db = 16'(int'(it.seg_min_db) + int'($urandom_range(0, 6000)));
          end
          if ($urandom_range(0, 7) == 0) it.seg_max_volume = it.seg_min_volume;
        end
      end
      send_item(it);
    end
  endtask

  task automatic test_backpressure;
    burst_mode = 0;
    hold_off = 200;
    for (int n = 0; n < 30; n++) send_item(rand_item(FN_SAMPLE));
    burst_mode = 1;
    drain();
    for (int n = 0; n < 10; n++) send_item(rand_item(FN_MUTE));
  endtask

  // receiver stall pattern, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (n_results % 200 < 60) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item %p", $time, out_item);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_item.status == STS_SAT) n_sat++;
        if (out_item.status == STS_MISS) n_miss++;
        if (out_item.status == STS_REJECT) n_rej++;
        if (out_item.kind !== exp_r.kind || out_item.sample_out !== exp_r.sample_out ||
            out_item.last_of_block !== exp_r.last_of_block || out_item.gain !== exp_r.gain ||
            out_item.muted !== exp_r.muted || out_item.status !== exp_r.status ||
            out_item.matched_segment !== exp_r.matched_segment) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_item);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    seg_cnt = 0;
    cur_gain = UNITY_GAIN;
    cur_mute = 0;
    cur_seg = 0;
    for (int i = 0; i < NUM_SEGMENTS; i++) begin
      tbl_lo[i] = 0; tbl_hi[i] = 0; tbl_db[i] = 0; tbl_slope[i] = 0;
    end
    repeat (2) @(negedge clk);
    rst_n = 1;
    test_directed();
    test_backpressure();
    test_random(350, 4'd8);
    test_random(350, 4'd3);
    test_random(350, 4'd0);
    test_random(350, 4'd12);
    drain();
    $display("ran %0d results: %0d saturated, %0d unmatched volumes, %0d rejected writes",
             n_results, n_sat, n_miss, n_rej);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/pwdb_pkg.sv
rtl/core/pwdb_div.sv
rtl/core/pwdb_dp.sv
rtl/core/pwdb_ctrl.sv
rtl/core/piecewise_db_volume_gain.sv
sim/tb.sv
